// File: hw/rtl/inverse_53_lifting_row_core_assert.svh
// Assertion macros for the inverse 5/3 row core checker.
// Plain text macros only; no dependencies.
`ifndef INVERSE_53_LIFTING_ROW_CORE_ASSERT_SVH
`define INVERSE_53_LIFTING_ROW_CORE_ASSERT_SVH

// Condition a implies c in the same cycle.
`define I53_ASSERT_SAME(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("i53row assertion failed");

// Condition a implies c in the next cycle.
`define I53_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("i53row assertion failed");

// Condition a implies c, with c checked later than in I53_ASSERT_NEXT.
`define I53_ASSERT_LATER2(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##2 (c)) \
		else $error("i53row assertion failed");

`endif

// File: hw/rtl/i53row_pkg.sv
// Shared types, constants and helpers for the inverse 5/3 row core.
// No dependencies.
package i53row_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int HIGH_W     = 16;
	localparam int SHIFT_W    = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam int MAX_RES    = 3;
	localparam int CNT_W      = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HF_SHIFT   = 1'b0,
		REG_LF_SHIFTED = 1'b1
	} cfg_reg_t;

	// One buffered result
	typedef struct packed {
		logic [SAMPLE_W-1:0] pix;
		logic                run_end;
		logic                line_end;
	} result_t;

	// Sign extend a 16-bit coefficient to the datapath width
	function automatic logic [SAMPLE_W-1:0] sext16(input logic [HIGH_W-1:0] v);
		return {{(SAMPLE_W-HIGH_W){v[HIGH_W-1]}}, v};
	endfunction

	// Arithmetic shift right by one
	function automatic logic [SAMPLE_W-1:0] asr1(input logic [SAMPLE_W-1:0] x);
		return {x[SAMPLE_W-1], x[SAMPLE_W-1:1]};
	endfunction

	// Arithmetic shift right by two
	function automatic logic [SAMPLE_W-1:0] asr2(input logic [SAMPLE_W-1:0] x);
		return {{2{x[SAMPLE_W-1]}}, x[SAMPLE_W-1:2]};
	endfunction

endpackage

// File: hw/rtl/inverse_53_lifting_row_core.sv
// Inverse 5/3 lifting, horizontal, streamed one low-pass position per request.
// Order: an accepted request is held in the input register, and its results move into
//   the result buffer once the buffer is free.
// Each request causes 1 to 3 results (2 mid-line), drained by the single output port
//   from the 3-entry result buffer; the next request loads as its last result leaves.
// Reset (arst_n low, asynchronous) clears config, held samples, line state, valids.
module inverse_53_lifting_row_core
	import i53row_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [SAMPLE_W-1:0]   low_sample,
	input  logic signed [HIGH_W-1:0]     high_sample,
	input  logic                         high_present,
	input  logic                         line_last,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [SAMPLE_W-1:0]   pixel_value,
	output logic                         run_end,
	output logic                         line_end
);

	logic [SHIFT_W-1:0]  hf_shift_q;
	logic                lf_shifted_q;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] low_s1;
	logic [HIGH_W-1:0]   high_s1;
	logic                present_s1;
	logic                last_s1;

	logic [SAMPLE_W-1:0] held_even_q;
	logic [SAMPLE_W-1:0] held_high_q;
	logic                inside_q;

	result_t             res_q [MAX_RES];
	logic [CNT_W-1:0]    cnt_q;

	logic                in_take;
	logic                out_take;
	logic                load;

	logic [SAMPLE_W-1:0] hs;
	logic [SAMPLE_W-1:0] ls;
	logic                first;
	logic [SAMPLE_W-1:0] corr_sum;
	logic [SAMPLE_W-1:0] corr;
	logic [SAMPLE_W-1:0] even_val;
	logic [SAMPLE_W-1:0] odd_val;
	logic [SAMPLE_W-1:0] tail_val;
	logic [SAMPLE_W-1:0] hcur;
	logic                tail;
	logic [CNT_W-1:0]    n_res;
	result_t             ent [MAX_RES];

	// Handshakes
	assign cfg_ready = 1'b1;
	assign out_valid = (cnt_q != '0);
	assign out_take  = out_valid && !out_stall;
	assign load      = valid_s1 && ((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_take));
	assign in_stall  = valid_s1 && !load;
	assign in_take   = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hf_shift_q   <= '0;
			lf_shifted_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HF_SHIFT:   hf_shift_q   <= cfg_data[SHIFT_W-1:0];
				REG_LF_SHIFTED: lf_shifted_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			low_s1     <= low_sample;
			high_s1    <= high_sample;
			present_s1 <= high_present;
			last_s1    <= line_last;
		end
	end

	// Lifting arithmetic for the registered request
	always_comb begin
		hs    = sext16(high_s1) << hf_shift_q;
		ls    = lf_shifted_q ? (sext16(low_s1[HIGH_W-1:0]) << hf_shift_q) : low_s1;
		first = !inside_q;
		tail  = last_s1 && present_s1;

		// update step: mirrored neighbor at line start, missing neighbor at odd end
		if (present_s1) begin
			corr_sum = first ? (hs + SAMPLE_W'(1)) : (held_high_q + hs + SAMPLE_W'(2));
		end else begin
			corr_sum = first ? '0 : (held_high_q + SAMPLE_W'(1));
		end
		corr     = (present_s1 && !first) ? asr2(corr_sum) : asr1(corr_sum);
		even_val = ls - corr;

		// predict step
		odd_val  = held_high_q + asr1(held_even_q + even_val);
		tail_val = hs + even_val;
		hcur     = present_s1 ? hs : (first ? '0 : held_high_q);

		// order the results
		for (int i = 0; i < MAX_RES; i++) begin
			ent[i] = '0;
		end
		if (first) begin
			ent[0].pix = even_val;
			ent[1].pix = tail_val;
			n_res      = tail ? CNT_W'(2) : CNT_W'(1);
		end else begin
			ent[0].pix = odd_val;
			ent[1].pix = even_val;
			ent[2].pix = tail_val;
			n_res      = tail ? CNT_W'(3) : CNT_W'(2);
		end
		for (int i = 0; i < MAX_RES; i++) begin
			ent[i].run_end  = (CNT_W'(i) == (n_res - CNT_W'(1)));
			ent[i].line_end = ent[i].run_end && last_s1;
		end
	end

	// Held line state, updated as a request moves into the result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_even_q <= '0;
			held_high_q <= '0;
			inside_q    <= 1'b0;
		end else if (load) begin
			held_even_q <= even_val;
			held_high_q <= hcur;
			inside_q    <= !last_s1;
		end
	end

	// Result buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= n_res;
		end else if (out_take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Result buffer payload, head in entry 0
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RES; i++) begin
				res_q[i] <= ent[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

	assign pixel_value = res_q[0].pix;
	assign run_end     = res_q[0].run_end;
	assign line_end    = res_q[0].line_end;

endmodule

// File: hw/rtl/i53row_chk.sv
// Port-level checker for the inverse 5/3 row core, and its bind.
// Depends on i53row_pkg and inverse_53_lifting_row_core_assert.svh.
`include "inverse_53_lifting_row_core_assert.svh"

module i53row_chk
	import i53row_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [SAMPLE_W-1:0] pixel_value,
	input logic                       run_end,
	input logic                       line_end
);

	// Whole output payload, for the hold check
	logic [SAMPLE_W+1:0] out_word;

	assign out_word = {pixel_value, run_end, line_end};

	// A held result keeps its value while stalled
	`I53_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_word))

	// The end of a line always closes the run of its request
	`I53_ASSERT_SAME(a_line_end_run, clk, arst_n, out_valid && line_end, run_end)

	// Input backs up only behind pending results
	`I53_ASSERT_SAME(a_stall_cause, clk, arst_n, in_stall, out_valid)

	// Every accepted request has results pending once it has passed the input register
	`I53_ASSERT_LATER2(a_req_out, clk, arst_n, in_valid && !in_stall, out_valid)

endmodule

bind inverse_53_lifting_row_core i53row_chk u_i53row_chk (.*);

// File: dv/tb_inverse_53_lifting_row_core.sv
// Testbench for inverse_53_lifting_row_core: drives lines of 5/3 coefficients and
// checks the reconstructed pixels against a line-level lifting predictor.
// Depends on i53row_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_inverse_53_lifting_row_core;
	import i53row_pkg::*;

	localparam int RANDOM_REQUESTS = 460;
	localparam int CYCLE_LIMIT     = 300000;
	localparam int HOLD_CYCLES     = 80;

	// Predicts the pixels of each request and checks them in order
	class line_scoreboard;
		logic [SHIFT_W-1:0]  hf_shift;
		logic                lf_shifted;
		logic [SAMPLE_W-1:0] last_even;
		logic [SAMPLE_W-1:0] prev_high;
		logic                line_open;
		result_t             expected_pixels[$];
		int                  errors;

		function new();
			hf_shift   = '0;
			lf_shifted = 1'b0;
			last_even  = '0;
			prev_high  = '0;
			line_open  = 1'b0;
			errors     = 0;
		endfunction

		function automatic logic [SAMPLE_W-1:0] sra(input logic signed [SAMPLE_W-1:0] x,
				input int n);
			return x >>> n;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_HF_SHIFT) begin
				hf_shift = data[SHIFT_W-1:0];
			end else begin
				lf_shifted = data[0];
			end
		endfunction

		// Work out the pixels that one accepted request produces
		function void note_request(logic [SAMPLE_W-1:0] low, logic [HIGH_W-1:0] high,
				logic present, logic last);
			logic [SAMPLE_W-1:0] hs, ls, even, held;
			result_t             r;

			hs = {{(SAMPLE_W-HIGH_W){high[HIGH_W-1]}}, high} << hf_shift;
			ls = lf_shifted ? ({{(SAMPLE_W-HIGH_W){low[HIGH_W-1]}}, low[HIGH_W-1:0]}
				<< hf_shift) : low;
			r.run_end  = 1'b0;
			r.line_end = 1'b0;
			if (!line_open) begin
				// mirrored H[-1] at line start; zero high when absent
				even = present ? ls - sra(hs + 32'd1, 1) : ls;
				held = present ? hs : '0;
			end else begin
				if (present) begin
					even = ls - sra(prev_high + hs + 32'd2, 2);
					held = hs;
				end else begin
					even = ls - sra(prev_high + 32'd1, 1);
					held = prev_high;
				end
				r.pix = prev_high + sra(last_even + even, 1);
				expected_pixels.push_back(r);
			end
			r.pix = even;
			expected_pixels.push_back(r);
			// even-length line closes with a mirrored odd
			if (last && present) begin
				r.pix = hs + even;
				expected_pixels.push_back(r);
			end
			expected_pixels[$].run_end  = 1'b1;
			expected_pixels[$].line_end = last;
			last_even = even;
			prev_high = held;
			line_open = !last;
		endfunction

		function void check_pixel(logic [SAMPLE_W-1:0] pix, logic re, logic le);
			result_t exp_r;

			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected pixel %h run_end %b line_end %b", $time, pix, re, le);
				errors++;
				return;
			end
			exp_r = expected_pixels.pop_front();
			if (pix !== exp_r.pix) begin
				$display("%0t: pixel_value expected %h actual %h", $time, exp_r.pix, pix);
				errors++;
			end
			if (re !== exp_r.run_end) begin
				$display("%0t: run_end expected %b actual %b", $time, exp_r.run_end, re);
				errors++;
			end
			if (le !== exp_r.line_end) begin
				$display("%0t: line_end expected %b actual %b", $time, exp_r.line_end, le);
				errors++;
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	cfg_reg_t                   cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] low_sample;
	logic signed [HIGH_W-1:0]   high_sample;
	logic                       high_present;
	logic                       line_last;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] pixel_value;
	logic                       run_end;
	logic                       line_end;

	line_scoreboard sb = new();

	int  cycles       = 0;
	int  requests     = 0;
	int  burst_left   = 0;
	bit  gaps_on      = 1'b0;
	int  hold_token   = 0;
	int  hold_seen    = 0;
	int  hold_left    = 0;
	int  seg_left     = 0;
	int  stall_mode   = 0;

	inverse_53_lifting_row_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.low_sample   (low_sample),
		.high_sample  (high_sample),
		.high_present (high_present),
		.line_last    (line_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_value  (pixel_value),
		.run_end      (run_end),
		.line_end     (line_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver stall: random segments of patterns, plus long holds on request
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			if (seg_left == 0) begin
				seg_left   <= $urandom_range(16, 160);
				stall_mode <= $urandom_range(0, 4);
			end else begin
				seg_left <= seg_left - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				3: out_stall <= cycles[0];
				default: out_stall <= (cycles % 5 == 0);
			endcase
		end
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pixel(pixel_value, run_end, line_end);
	end

	// Offer one request and wait until it is taken
	task automatic send(logic [SAMPLE_W-1:0] low, logic [HIGH_W-1:0] high,
			logic present, logic last);
		in_valid     <= 1'b1;
		low_sample   <= low;
		high_sample  <= high;
		high_present <= present;
		line_last    <= last;
		do @(posedge clk); while (in_stall);
		sb.note_request(low, high, present, last);
		requests++;
	endtask

	task automatic pause(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Send with bursts and gaps
	task automatic offer(logic [SAMPLE_W-1:0] low, logic [HIGH_W-1:0] high,
			logic present, logic last);
		if (burst_left == 0) begin
			if (gaps_on)
				pause($urandom_range(1, 6));
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		send(low, high, present, last);
	endtask

	// Stop sending until every expected pixel is back, then let the core settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_low();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			1: return $urandom_range(0, 64) - 32;
			2: return {{16{1'b0}}, 16'($urandom)} ^ ($urandom_range(0, 1) ? 32'hffff_0000 : 0);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [HIGH_W-1:0] rand_high();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			1: return 16'($urandom_range(0, 32) - 16);
			default: return 16'($urandom);
		endcase
	endfunction

	// One line of n reconstructed samples; noisy lines toggle highs or end early
	task automatic run_line(int n, bit noisy);
		int  lows;
		bit  last;
		bit  present;

		lows = (n + 1) / 2;
		for (int k = 0; k < lows; k++) begin
			last    = (k == lows - 1);
			present = last ? (n % 2 == 0) : 1'b1;
			if (noisy && $urandom_range(0, 4) == 0)
				present = ~present;
			if (noisy && $urandom_range(0, 9) == 0)
				last = 1'b1;
			offer(rand_low(), rand_high(), present, last);
			if (last)
				break;
		end
	endtask

	initial begin
		int  phase;
		int  phase_left;
		bit  hold_done;

		arst_n       = 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_HF_SHIFT;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		low_sample   <= '0;
		high_sample  <= '0;
		high_present <= 1'b0;
		line_last    <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-sample line without a high sample
		send(32'h7fff_ffff, 16'h1234, 1'b0, 1'b1);
		// two-sample line: first even, then the final odd
		send(32'h8000_0000, 16'h7fff, 1'b1, 1'b1);
		// odd-length line closing without a high sample
		send(32'hffff_ffff, 16'h8000, 1'b1, 1'b0);
		send(32'h7fff_ffff, 16'h7fff, 1'b1, 1'b0);
		send(32'h8000_0000, 16'h0001, 1'b0, 1'b1);
		// missing high in mid-line repeats the previous one
		send(32'd5, 16'd100, 1'b1, 1'b0);
		send(32'd7, 16'hbeef, 1'b0, 1'b0);
		send(32'd9, 16'hfffd, 1'b1, 1'b1);
		// line start without a high sample, line goes on
		send(32'd123, 16'h5555, 1'b0, 1'b0);
		send(32'hffff_0000, 16'haaaa, 1'b1, 1'b1);
		// register writes while a line is open keep the held samples
		send(32'h0001_2345, 16'h0f0f, 1'b1, 1'b0);
		drain();
		write_reg(REG_HF_SHIFT, 4'd15);
		write_reg(REG_LF_SHIFTED, 4'd1);
		send(32'hffff_8000, 16'h8000, 1'b1, 1'b0);
		send(32'h0000_7fff, 16'h7fff, 1'b1, 1'b0);
		send(32'h5a5a_8000, 16'h8000, 1'b1, 1'b1);
		drain();
		write_reg(REG_HF_SHIFT, 4'd7);
		write_reg(REG_LF_SHIFTED, 4'd0);
		send(32'h8000_0000, 16'h8000, 1'b1, 1'b0);
		send(32'h7fff_ffff, 16'h7fff, 1'b0, 1'b1);

		// Random lines in phases of register settings
		phase      = 0;
		phase_left = 0;
		hold_done  = 1'b0;
		while (requests < RANDOM_REQUESTS + 18) begin
			if (phase_left <= 0) begin
				drain();
				case (phase % 4)
					0: write_reg(REG_HF_SHIFT, 4'd0);
					1: write_reg(REG_HF_SHIFT, 4'd15);
					default: write_reg(REG_HF_SHIFT, 4'($urandom));
				endcase
				write_reg(REG_LF_SHIFTED, {3'($urandom), 1'($urandom)});
				phase++;
				phase_left = $urandom_range(30, 80);
			end
			if (!hold_done && requests > 200) begin
				// long receiver hold while requests keep coming back to back
				hold_token <= hold_token + 1;
				gaps_on    = 1'b0;
				burst_left = 0;
				run_line(60, 1'b0);
				hold_done = 1'b1;
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			phase_left -= requests;
			run_line(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12),
				($urandom_range(0, 4) == 0));
			phase_left += requests;
			phase_left -= 1;
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
